/* hw/rtl/u16d_pkg.sv */
// Package with the constants and types shared by the UTF-16LE decoder files.
package u16d_pkg;

  // High-byte window that opens a surrogate pair: 0xD8 up to, not including, 0xE0.
  localparam logic [7:0]  SURR_LOW_HI  = 8'hD8;
  localparam logic [7:0]  SURR_END_HI  = 8'hE0;
  localparam logic [15:0] REPLACE_CODE = 16'h003F;
  localparam logic [15:0] TERM_CODE    = 16'h0000;

  // Default depth of the result queue; it must be at least two.
  localparam int OUT_FIFO_DEPTH = 4;

  // Position of the next byte within a unit or a surrogate pair.
  typedef enum logic [1:0] {
    POS_UNIT_LO = 2'd0,
    POS_UNIT_HI = 2'd1,
    POS_PAIR_LO = 2'd2,
    POS_PAIR_HI = 2'd3
  } byte_pos_t;

  // One result word as it sits in the result queue.
  typedef struct packed {
    logic [15:0] char_code;
    logic        out_last;
  } result_t;

endpackage

/* hw/rtl/u16d_if.sv */
// Channel interfaces of the UTF-16LE decoder: byte input, result output, configuration.
interface u16d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u16d_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        out_last;

  modport source (output valid, output char_code, output out_last, input ready);
  modport sink   (input valid, input char_code, input out_last, output ready);
endinterface

interface u16d_cfg_if;
  logic valid;
  logic ready;
  logic narrow_mode;

  modport source (output valid, output narrow_mode, input ready);
  modport sink   (input valid, input narrow_mode, output ready);
endinterface

/* hw/rtl/utf16le_to_narrow_code_decoder_top.sv */
// Top level of the UTF-16LE decoder with replacement of out-of-range units.
//
// The decoder takes one byte of a little-endian UTF-16 string per word on the
// input channel and gives decoded character codes on the output channel. Two
// bytes form a code unit, low byte first. A unit whose high byte lies in
// 0xD8..0xDF opens a four-byte surrogate pair, which always decodes to '?'
// (0x3F). Any other unit is given as it is in wide mode, and as '?' in narrow
// mode when it is 0x100 or above. After the byte marked last, a terminator word
// with code 0 and out_last set follows; an odd final byte or an unfinished pair
// is dropped, and the decoder starts the next string from scratch. A byte is
// accepted in every cycle while the result queue has room for two words, and
// its results go into the registered queue behind any words held there. The
// sustained rate is one byte per cycle while the queue has room; the output
// side sets the pace, at one result word per cycle, so a byte that yields a
// character and the terminator gives two output words. narrow_mode is written
// through the always-ready configuration channel and resets to wide mode.
module utf16le_to_narrow_code_decoder_top
  import u16d_pkg::*;
#(
  parameter int FIFO_DEPTH = OUT_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  u16d_in_if.sink           in_ch,
  u16d_out_if.source        out_ch,
  u16d_cfg_if.sink          cfg_ch
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // Decoder state.
  byte_pos_t   pos_r, pos_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic        surr_r, surr_nxt;
  logic        narrow_mode_r;

  // Result queue, kept in registers.
  result_t            fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic        in_fire;
  logic        out_fire;
  logic        emit_char;
  logic [15:0] char_code;
  logic [1:0]  push_n;
  logic [PTR_W-1:0] wr_ptr_inc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // User writes configuration register only while decoder is idle; unenforced.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      narrow_mode_r <= cfg_ch.narrow_mode;
    end
  end

  // A byte is taken only when two queue slots are free, so that a character
  // and a terminator can always be stored together.
  assign in_ch.ready = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  // Per-byte decode. Positions 2 and 3 are always inside a pair.
  always_comb begin
    pos_nxt      = pos_r;
    low_byte_nxt = low_byte_r;
    surr_nxt     = surr_r;
    emit_char    = 1'b0;
    char_code    = {in_ch.in_byte, low_byte_r};
    case (pos_r)
      POS_UNIT_LO: begin
        low_byte_nxt = in_ch.in_byte;
        pos_nxt      = POS_UNIT_HI;
      end
      POS_UNIT_HI: begin
        if (in_ch.in_byte >= SURR_LOW_HI && in_ch.in_byte < SURR_END_HI) begin
          surr_nxt = 1'b1;
          pos_nxt  = POS_PAIR_LO;
        end else begin
          emit_char = 1'b1;
          // In narrow mode any nonzero high byte puts the unit at or above 0x100.
          if (narrow_mode_r && in_ch.in_byte != 8'h00) begin
            char_code = REPLACE_CODE;
          end
          pos_nxt = POS_UNIT_LO;
        end
      end
      POS_PAIR_LO: begin
        surr_nxt = 1'b1;
        pos_nxt  = POS_PAIR_HI;
      end
      POS_PAIR_HI: begin
        emit_char = 1'b1;
        char_code = REPLACE_CODE;
        pos_nxt   = POS_UNIT_LO;
        surr_nxt  = 1'b0;
      end
      default: begin
        pos_nxt = POS_UNIT_LO;
      end
    endcase
    // The end of a string clears all decode state.
    if (in_ch.in_last) begin
      pos_nxt      = POS_UNIT_LO;
      low_byte_nxt = 8'h00;
      surr_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_UNIT_LO;
      low_byte_r <= 8'h00;
      surr_r     <= 1'b0;
    end else if (in_fire) begin
      pos_r      <= pos_nxt;
      low_byte_r <= low_byte_nxt;
      surr_r     <= surr_nxt;
    end
  end

  // Queue bookkeeping.
  assign push_n     = in_fire ? ({1'b0, emit_char} + {1'b0, in_ch.in_last}) : 2'd0;
  assign wr_ptr_inc = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr_ptr_inc;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_inc);
    end
    rd_ptr_nxt = out_fire ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage: the character goes first, the terminator behind it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (emit_char) begin
        fifo_r[wr_ptr_r] <= '{char_code: char_code, out_last: 1'b0};
        if (in_ch.in_last) begin
          fifo_r[wr_ptr_inc] <= '{char_code: TERM_CODE, out_last: 1'b1};
        end
      end else if (in_ch.in_last) begin
        fifo_r[wr_ptr_r] <= '{char_code: TERM_CODE, out_last: 1'b1};
      end
    end
  end

  assign out_ch.valid     = (count_r != '0);
  assign out_ch.char_code = fifo_r[rd_ptr_r].char_code;
  assign out_ch.out_last  = fifo_r[rd_ptr_r].out_last;

  // The pair flag follows the position: set exactly in the two pair positions.
  a_surr_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
    surr_r == pos_r[1])
    else $error("surrogate flag disagrees with byte position");

  // The queue never holds more words than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // A final byte always returns the decoder to the start of a unit.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.in_last) |=> (pos_r == POS_UNIT_LO && !surr_r))
    else $error("decode state not cleared after final byte");

  // Every accepted final byte puts a terminator at the tail of the queue.
  a_last_queues_term: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.in_last) |=> (count_r != '0))
    else $error("terminator not queued after final byte");

endmodule
